@@ src/pidsc_pkg.sv @@
// ============================================================================
// pidsc_pkg: shared types and constants of the PID axis with settle count
// Holds field widths, register indexes, reset values, the sequencer states
// and a small helper function; the core and the testbench import it.
// ============================================================================
package pidsc_pkg;

    // Defaults for the top level parameters.
    localparam int FRAC_BITS_DEF = 16;
    localparam int ACC_WIDTH_DEF = 48;

    // Fixed field widths.
    localparam int DATA_W  = 32;
    localparam int MS_W    = 16;
    localparam int TOL_W   = 31;
    localparam int COUNT_W = 4;
    localparam int ADDR_W  = 5;
    localparam int IDX_W   = 3;
    localparam int LIMB_W  = 32;
    localparam int CNT_W   = 5;

    // Sequencer step counts.
    localparam int DIV_STEPS = 32;
    localparam int MUL_STEPS = 4;

    localparam logic [COUNT_W-1:0] SETTLE_MAX       = 4'd15;
    localparam logic [COUNT_W-1:0] SETTLE_LIMIT_RST = 4'd10;

    localparam logic [DATA_W-1:0] INT32_MAX_C = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] INT32_MIN_C = 32'h8000_0000;

    // Register indexes on the configuration port (byte address / 4).
    typedef logic [IDX_W-1:0] reg_idx_t;
    localparam reg_idx_t REG_TARGET       = 3'd0;
    localparam reg_idx_t REG_GAIN_P       = 3'd1;
    localparam reg_idx_t REG_GAIN_I       = 3'd2;
    localparam reg_idx_t REG_GAIN_D       = 3'd3;
    localparam reg_idx_t REG_TOLERANCE    = 3'd4;
    localparam reg_idx_t REG_SETTLE_LIMIT = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_UPD,
        ST_DIV,
        ST_MUL,
        ST_FINAL,
        ST_HOLD
    } state_t;

    // Magnitude of a 32-bit two's complement value as an unsigned word.
    function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] r;
        r = v[DATA_W-1] ? (~v + 32'd1) : v;
        return r;
    endfunction

endpackage

@@ src/pid_axis_with_settle_count_core.sv @@
// ============================================================================
// pid_axis_with_settle_count_core: one PID axis step in signed fixed point
// Computes error, derivative, saturating integral and the saturated drive
// with a settle count of in-band steps that zeroes the drive at the limit.
// ============================================================================
// One input beat (measured position, elapsed milliseconds, restart flag)
// produces exactly one output beat (drive, settled, error_out). A step that
// is not settled runs through the error, update, divide, multiply, final and
// hold states before its result reaches the output register, and the next
// beat is taken only after that, so one step is in flight at a time. The
// derivative is formed by the 32-step restoring divider, one quotient
// bit per cycle, followed by four passes through a single 32 x 32 multiplier
// (error times gain_p, derivative times gain_d, and the low and high words
// of the integral times gain_i), each partial product added into a wide
// accumulator in the cycle after it is formed. A settled step skips the
// divider and the multiplier and goes from the update state to the hold
// state. The input is stalled while a step is in flight; a finished result
// waits in the hold state until the output register has been handed over or
// is free, and the block then goes back to taking input. Configuration is
// written over an APB-style port with pready tied high, and should only be
// written while no step is in flight.
// ============================================================================
module pid_axis_with_settle_count_core
    import pidsc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    // Input channel.
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [DATA_W-1:0]        measured,
    input  logic [MS_W-1:0]          elapsed_ms,
    input  logic                     restart,

    // Output channel.
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [DATA_W-1:0]        drive,
    output logic                     settled,
    output logic [DATA_W-1:0]        error_out,

    // Configuration port.
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready
);

    // The exact sum of the three products needs at most ACC_WIDTH + 33 bits;
    // one more bit of margin keeps the sign clean.
    localparam int SUM_W = ACC_WIDTH + 34;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(((7 << FRAC_BITS) + 50) / 100);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_STEPS - 1);
    localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(MUL_STEPS);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DATA_W-1:0]  target_reg;
    logic [DATA_W-1:0]  gain_p_reg;
    logic [DATA_W-1:0]  gain_i_reg;
    logic [DATA_W-1:0]  gain_d_reg;
    logic [TOL_W-1:0]   tolerance_reg;
    logic [COUNT_W-1:0] settle_limit_reg;

    logic               cfg_wr;
    reg_idx_t           cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg       <= '0;
            gain_p_reg       <= '0;
            gain_i_reg       <= '0;
            gain_d_reg       <= '0;
            tolerance_reg    <= TOL_RESET;
            settle_limit_reg <= SETTLE_LIMIT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_TARGET:       target_reg       <= pwdata;
                REG_GAIN_P:       gain_p_reg       <= pwdata;
                REG_GAIN_I:       gain_i_reg       <= pwdata;
                REG_GAIN_D:       gain_d_reg       <= pwdata;
                REG_TOLERANCE:    tolerance_reg    <= pwdata[TOL_W-1:0];
                REG_SETTLE_LIMIT: settle_limit_reg <= pwdata[COUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_TARGET:       prdata = target_reg;
            REG_GAIN_P:       prdata = gain_p_reg;
            REG_GAIN_I:       prdata = gain_i_reg;
            REG_GAIN_D:       prdata = gain_d_reg;
            REG_TOLERANCE:    prdata = {1'b0, tolerance_reg};
            REG_SETTLE_LIMIT: prdata = {{(DATA_W-COUNT_W){1'b0}}, settle_limit_reg};
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Controller state and working registers
    // ------------------------------------------------------------------
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    logic [ACC_WIDTH-1:0] integral_reg;
    logic [DATA_W-1:0]    last_error_reg;
    logic [COUNT_W-1:0]   settle_count_reg;

    // Latched input beat.
    logic [DATA_W-1:0]    meas_reg;
    logic [MS_W-1:0]      ms_reg;
    logic                 restart_reg;

    logic [DATA_W-1:0]    err_reg;
    logic                 diff_neg_reg;
    logic [DATA_W-1:0]    div_num_reg;
    logic [MS_W-1:0]      div_rem_reg;

    logic [DATA_W-1:0]    emag_reg;
    logic [2*LIMB_W-1:0]  imag_reg;
    logic                 i_neg_reg;
    logic [DATA_W-1:0]    gp_mag_reg;
    logic [DATA_W-1:0]    gi_mag_reg;
    logic [DATA_W-1:0]    gd_mag_reg;

    logic [2*LIMB_W-1:0]  pp_reg;
    logic                 pp_neg_reg;
    logic                 pp_hi_reg;
    logic signed [SUM_W-1:0] acc_reg;

    logic [DATA_W-1:0]    res_drive_reg;
    logic                 res_settled_reg;

    logic                 out_valid_reg;
    logic [DATA_W-1:0]    drive_reg;
    logic                 settled_reg;
    logic [DATA_W-1:0]    error_out_reg;

    // ------------------------------------------------------------------
    // Error: target minus measured, saturated to 32 bits
    // ------------------------------------------------------------------
    logic [DATA_W:0]   e_full;
    logic [DATA_W-1:0] e_sat;

    assign e_full = {target_reg[DATA_W-1], target_reg} - {meas_reg[DATA_W-1], meas_reg};

    always_comb
    begin
        if (e_full[DATA_W] != e_full[DATA_W-1])
        begin
            e_sat = e_full[DATA_W] ? INT32_MIN_C : INT32_MAX_C;
        end
        else
        begin
            e_sat = e_full[DATA_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // State update: band test, integral, settle count, derivative numerator
    // ------------------------------------------------------------------
    logic [DATA_W-1:0]     last_eff;
    logic [ACC_WIDTH-1:0]  integ_eff;
    logic [COUNT_W-1:0]    count_eff;
    logic [DATA_W:0]       diff;
    logic [DATA_W:0]       diff_abs;
    logic signed [DATA_W:0] e_ext;
    logic signed [DATA_W:0] tol_ext;
    logic                  in_band;
    logic [ACC_WIDTH:0]    integ_sum;
    logic [ACC_WIDTH-1:0]  integ_sat;
    logic [ACC_WIDTH-1:0]  integ_new;
    logic [COUNT_W-1:0]    count_new;
    logic                  settle_now;

    // A restart clears the carried state before this step uses it.
    assign last_eff  = restart_reg ? '0 : last_error_reg;
    assign integ_eff = restart_reg ? '0 : integral_reg;
    assign count_eff = restart_reg ? '0 : settle_count_reg;

    assign diff     = {err_reg[DATA_W-1], err_reg} - {last_eff[DATA_W-1], last_eff};
    assign diff_abs = diff[DATA_W] ? (~diff + 1'b1) : diff;

    assign e_ext   = {err_reg[DATA_W-1], err_reg};
    assign tol_ext = {2'b00, tolerance_reg};
    assign in_band = (e_ext < tol_ext) && (e_ext > -tol_ext);

    assign integ_sum = {integ_eff[ACC_WIDTH-1], integ_eff}
                     + {{(ACC_WIDTH-DATA_W+1){err_reg[DATA_W-1]}}, err_reg};

    always_comb
    begin
        if (integ_sum[ACC_WIDTH] != integ_sum[ACC_WIDTH-1])
        begin
            // Clamp to the most negative or most positive accumulator value.
            integ_sat = {integ_sum[ACC_WIDTH], {(ACC_WIDTH-1){~integ_sum[ACC_WIDTH]}}};
        end
        else
        begin
            integ_sat = integ_sum[ACC_WIDTH-1:0];
        end
    end

    always_comb
    begin
        if (in_band)
        begin
            integ_new = '0;
            count_new = (count_eff == SETTLE_MAX) ? count_eff : count_eff + 1'b1;
        end
        else
        begin
            integ_new = integ_sat;
            count_new = '0;
        end
    end

    assign settle_now = (count_new >= settle_limit_reg);

    // ------------------------------------------------------------------
    // Restoring divider step: one quotient bit per cycle
    // ------------------------------------------------------------------
    logic [MS_W:0]   rem_shift;
    logic            div_ge;
    logic [MS_W:0]   rem_sub;
    logic [MS_W-1:0] rem_new;
    logic            div_last;

    assign rem_shift = {div_rem_reg, div_num_reg[DATA_W-1]};
    assign div_ge    = (rem_shift >= {1'b0, ms_reg});
    assign rem_sub   = rem_shift - {1'b0, ms_reg};
    assign rem_new   = div_ge ? rem_sub[MS_W-1:0] : rem_shift[MS_W-1:0];
    assign div_last  = (cnt_reg == DIV_LAST);

    // Integral magnitude for the multiplier, taken from the updated state.
    logic [ACC_WIDTH-1:0] integ_abs;
    assign integ_abs = integral_reg[ACC_WIDTH-1] ? (~integral_reg + 1'b1) : integral_reg;

    // ------------------------------------------------------------------
    // Shared multiplier: operand selection by pass
    // ------------------------------------------------------------------
    logic [LIMB_W-1:0]   mul_a;
    logic [LIMB_W-1:0]   mul_b;
    logic                mul_neg;
    logic                mul_hi;
    logic [2*LIMB_W-1:0] mul_p;

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:
            begin
                mul_a   = emag_reg;
                mul_b   = gp_mag_reg;
                mul_neg = err_reg[DATA_W-1] ^ gain_p_reg[DATA_W-1];
                mul_hi  = 1'b0;
            end
            2'd1:
            begin
                // div_num_reg now holds the derivative magnitude.
                mul_a   = div_num_reg;
                mul_b   = gd_mag_reg;
                mul_neg = diff_neg_reg ^ gain_d_reg[DATA_W-1];
                mul_hi  = 1'b0;
            end
            2'd2:
            begin
                mul_a   = imag_reg[LIMB_W-1:0];
                mul_b   = gi_mag_reg;
                mul_neg = i_neg_reg ^ gain_i_reg[DATA_W-1];
                mul_hi  = 1'b0;
            end
            default:
            begin
                mul_a   = imag_reg[2*LIMB_W-1:LIMB_W];
                mul_b   = gi_mag_reg;
                mul_neg = i_neg_reg ^ gain_i_reg[DATA_W-1];
                mul_hi  = 1'b1;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    logic [SUM_W-1:0] pp_ext;
    assign pp_ext = pp_hi_reg ? SUM_W'({pp_reg, {LIMB_W{1'b0}}}) : SUM_W'(pp_reg);

    // ------------------------------------------------------------------
    // Final scaling and saturation of the drive
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] acc_shifted;
    logic                    acc_fits;
    logic [DATA_W-1:0]       drive_calc;

    assign acc_shifted = acc_reg >>> FRAC_BITS;
    assign acc_fits    = (&acc_shifted[SUM_W-1:DATA_W-1]) | ~(|acc_shifted[SUM_W-1:DATA_W-1]);

    always_comb
    begin
        if (acc_fits)
        begin
            drive_calc = acc_shifted[DATA_W-1:0];
        end
        else
        begin
            drive_calc = acc_shifted[SUM_W-1] ? INT32_MIN_C : INT32_MAX_C;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic out_free;
    logic take_in;
    logic load_out;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_ERR;
            ST_ERR:   state_next = ST_UPD;
            ST_UPD:   state_next = settle_now ? ST_HOLD : ST_DIV;
            ST_DIV:   if (div_last) state_next = ST_MUL;
            ST_MUL:   if (cnt_reg == MUL_LAST) state_next = ST_FINAL;
            ST_FINAL: state_next = ST_HOLD;
            ST_HOLD:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        take_in  = 1'b0;
        load_out = 1'b0;
        cnt_next = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                take_in  = in_valid;
            end
            ST_UPD:   cnt_next = '0;
            ST_DIV:   cnt_next = div_last ? '0 : cnt_reg + 1'b1;
            ST_MUL:   cnt_next = cnt_reg + 1'b1;
            ST_HOLD:  load_out = out_free;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            integral_reg     <= '0;
            last_error_reg   <= '0;
            settle_count_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (state_reg == ST_UPD)
            begin
                integral_reg     <= integ_new;
                settle_count_reg <= count_new;
                // A settled step keeps the previous error for the next derivative.
                last_error_reg   <= settle_now ? last_eff : err_reg;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers; their contents only matter under the sequencer.
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            meas_reg    <= measured;
            ms_reg      <= elapsed_ms;
            restart_reg <= restart;
        end

        if (state_reg == ST_ERR)
        begin
            err_reg <= e_sat;
        end

        if (state_reg == ST_UPD)
        begin
            diff_neg_reg    <= diff[DATA_W];
            div_num_reg     <= diff_abs[DATA_W-1:0];
            div_rem_reg     <= '0;
            res_settled_reg <= settle_now;
            res_drive_reg   <= '0;
            acc_reg         <= '0;
        end

        if (state_reg == ST_DIV)
        begin
            div_rem_reg <= rem_new;
            if (div_last && (ms_reg == '0))
            begin
                // No elapsed time: the derivative term is zero.
                div_num_reg <= '0;
            end
            else
            begin
                div_num_reg <= {div_num_reg[DATA_W-2:0], div_ge};
            end
            emag_reg   <= mag32(err_reg);
            imag_reg   <= (2*LIMB_W)'(integ_abs);
            i_neg_reg  <= integral_reg[ACC_WIDTH-1];
            gp_mag_reg <= mag32(gain_p_reg);
            gi_mag_reg <= mag32(gain_i_reg);
            gd_mag_reg <= mag32(gain_d_reg);
        end

        if (state_reg == ST_MUL)
        begin
            if (cnt_reg != MUL_LAST)
            begin
                pp_reg     <= mul_p;
                pp_neg_reg <= mul_neg;
                pp_hi_reg  <= mul_hi;
            end
            if (cnt_reg != '0)
            begin
                acc_reg <= pp_neg_reg ? (acc_reg - pp_ext) : (acc_reg + pp_ext);
            end
        end

        if (state_reg == ST_FINAL)
        begin
            res_drive_reg <= drive_calc;
        end

        if (load_out)
        begin
            drive_reg     <= res_drive_reg;
            settled_reg   <= res_settled_reg;
            error_out_reg <= err_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign settled   = settled_reg;
    assign error_out = error_out_reg;

endmodule

@@ src/pidsc_checker.sv @@
// ============================================================================
// pidsc_checker: port-level checks for the PID axis core
// Watches the handshakes and the result fields of the top level over time.
// ============================================================================
module pidsc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] drive,
    input logic        settled,
    input logic [31:0] error_out
);

    // A settled result always carries a zero drive.
    a_settled_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && settled) |-> (drive == 32'd0))
        else $error("settled result with nonzero drive");

    // Once a beat is taken the core is busy with it on the next cycle.
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after accepting a beat");

    // A fresh result only appears at the end of a busy step.
    a_result_from_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a step in flight");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(drive)
                                      && $stable(settled) && $stable(error_out)))
        else $error("stalled result changed");

endmodule

bind pid_axis_with_settle_count_core pidsc_checker u_pidsc_checker (.*);

@@ tb/pid_axis_with_settle_count_core_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pid_axis_with_settle_count_core_tb: self-checking bench for one PID axis
// Sends position beats through the valid/stall input channel. A local
// fixed-point model of the axis predicts each output beat, and the output
// beats are checked field by field. Gains, target, tolerance and settle
// limit are rewritten over the APB port between phases while the axis is
// idle. Both channels idle and stall at random.
// ============================================================================
module pid_axis_with_settle_count_core_tb;
    import pidsc_pkg::*;

    // The longest run is about 1660 beats at most, each a full step through the core,
    // plus random idle gaps on both sides. The limit is several times that.
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 50;
    localparam int RANDOM_PHASES = 14;
    localparam int BEATS_PER_PHASE = 100;

    // Index 7 decodes to no register, so a write there must change nothing.
    localparam reg_idx_t REG_SPARE = 3'd7;

    localparam longint I32_MAX = 64'sd2147483647;
    localparam longint I32_MIN = -64'sd2147483648;
    localparam longint ACC_MAX = (64'sd1 <<< (ACC_WIDTH_DEF - 1)) - 1;
    localparam longint ACC_MIN = -ACC_MAX - 1;

    typedef struct packed {
        logic [DATA_W-1:0] meas;
        logic [MS_W-1:0]   ms;
        logic              clr;
    } axis_step_t;

    typedef struct packed {
        logic [DATA_W-1:0] drive;
        logic              settled;
        logic [DATA_W-1:0] err;
    } axis_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [DATA_W-1:0] measured = '0;
    logic [MS_W-1:0]   elapsed_ms = '0;
    logic              restart = 1'b0;

    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [DATA_W-1:0] drive;
    logic              settled;
    logic [DATA_W-1:0] error_out;

    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // Local copy of the configuration registers, starting at reset values.
    logic signed [DATA_W-1:0] tgt_reg = '0;
    logic signed [DATA_W-1:0] kp_reg = '0;
    logic signed [DATA_W-1:0] ki_reg = '0;
    logic signed [DATA_W-1:0] kd_reg = '0;
    logic [TOL_W-1:0]         tol_reg = TOL_W'(((7 << FRAC_BITS_DEF) + 50) / 100);
    logic [COUNT_W-1:0]       limit_reg = SETTLE_LIMIT_RST;

    // Local copy of the controller state.
    logic signed [ACC_WIDTH_DEF-1:0] integ_sum = '0;
    logic signed [DATA_W-1:0]        prev_err = '0;
    logic [COUNT_W-1:0]              band_count = '0;

    axis_step_t steps_to_send[$];
    axis_out_t  queued_outputs[$];

    bit send_gaps = 1'b0;
    bit sink_stalls = 1'b0;
    int send_wait = 0;
    int stall_left = 0;
    int fail_count = 0;
    int cycle_count = 0;

    pid_axis_with_settle_count_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .measured   (measured),
        .elapsed_ms (elapsed_ms),
        .restart    (restart),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .drive      (drive),
        .settled    (settled),
        .error_out  (error_out),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Advances the axis model by one accepted beat and returns the output
    // beat that it should produce. All products are formed exactly in a
    // 128-bit signed word before the Q16.16 shift and the 32-bit clamp.
    function automatic axis_out_t pid_next_output(input logic [DATA_W-1:0] meas,
                                                  input logic [MS_W-1:0] ms,
                                                  input logic clr);
        axis_out_t res;
        longint err;
        longint delta;
        longint rate;
        longint acc;
        logic signed [127:0] t_p;
        logic signed [127:0] t_i;
        logic signed [127:0] t_d;
        logic signed [127:0] g;
        logic signed [127:0] total;
        if (clr)
        begin
            integ_sum = '0;
            prev_err = '0;
            band_count = '0;
        end
        err = longint'(tgt_reg) - longint'($signed(meas));
        if (err > I32_MAX)
            err = I32_MAX;
        if (err < I32_MIN)
            err = I32_MIN;

        // A zero time step leaves the derivative at zero instead of dividing.
        rate = 0;
        if (ms != '0)
        begin
            delta = err - longint'(prev_err);
            rate = delta / longint'(ms);
        end

        // The band is open on both sides, so a zero tolerance holds nothing.
        if (err < longint'(tol_reg) && err > -longint'(tol_reg))
        begin
            integ_sum = '0;
            if (band_count != SETTLE_MAX)
                band_count = band_count + 1'b1;
        end
        else
        begin
            acc = longint'(integ_sum) + err;
            if (acc > ACC_MAX)
                acc = ACC_MAX;
            if (acc < ACC_MIN)
                acc = ACC_MIN;
            integ_sum = acc[ACC_WIDTH_DEF-1:0];
            band_count = '0;
        end

        res.err = err[DATA_W-1:0];
        if (band_count >= limit_reg)
        begin
            // Settled: the drive is forced to zero and the last error is held.
            res.settled = 1'b1;
            res.drive = '0;
        end
        else
        begin
            t_p = err;
            g = kp_reg;
            t_p = t_p * g;
            t_d = rate;
            g = kd_reg;
            t_d = t_d * g;
            t_i = integ_sum;
            g = ki_reg;
            t_i = t_i * g;
            total = (t_p + t_d + t_i) >>> FRAC_BITS_DEF;
            if (total > 128'sh7FFF_FFFF)
                total = 128'sh7FFF_FFFF;
            else if (total < -128'sh8000_0000)
                total = -128'sh8000_0000;
            res.settled = 1'b0;
            res.drive = total[DATA_W-1:0];
            prev_err = err[DATA_W-1:0];
        end
        return res;
    endfunction

    // Idle length after a beat: mostly none, often short, now and
    // then a long stretch.
    function automatic int pick_gap(input bit enable);
        int r;
        if (!enable)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [MS_W-1:0] pick_ms();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        if (r < 80)
            return MS_W'($urandom_range(1, 20));
        return MS_W'($urandom());
    endfunction

    // Measured position that gives the wanted error against the current
    // target, clamped to the 32-bit range.
    function automatic logic [DATA_W-1:0] meas_for(input longint err);
        longint m;
        m = longint'(tgt_reg) - err;
        if (m > I32_MAX)
            m = I32_MAX;
        if (m < I32_MIN)
            m = I32_MIN;
        return m[DATA_W-1:0];
    endfunction

    // Gains are mostly moderate so the drive stays in range, with some
    // full-range values that drive it into saturation.
    function automatic logic [DATA_W-1:0] rand_gain();
        logic [DATA_W-1:0] m;
        if ($urandom_range(99) < 20)
            return $urandom();
        m = $urandom_range(0, 32'h0004_0000);
        return $urandom_range(1) ? -m : m;
    endfunction

    task automatic push_step(input logic [DATA_W-1:0] meas, input logic [MS_W-1:0] ms,
                             input logic clr);
        axis_step_t s;
        s.meas = meas;
        s.ms = ms;
        s.clr = clr;
        steps_to_send.push_back(s);
    endtask

    // APB write: a setup cycle, then an access cycle that completes on the
    // edge where pready is seen high. The local copy is updated afterwards.
    task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_TARGET:       tgt_reg = val;
            REG_GAIN_P:       kp_reg = val;
            REG_GAIN_I:       ki_reg = val;
            REG_GAIN_D:       kd_reg = val;
            REG_TOLERANCE:    tol_reg = val[TOL_W-1:0];
            REG_SETTLE_LIMIT: limit_reg = val[COUNT_W-1:0];
            default: ;
        endcase
    endtask

    // Waits until every queued beat has been sent and every predicted output
    // beat has come back. Sampling on the falling edge keeps clear of the
    // updates made at the rising edge.
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (steps_to_send.size() != 0 || in_valid || queued_outputs.size() != 0);
    endtask

    // Input driver. The model is stepped on each accepted beat, then the
    // next beat is presented, possibly after an idle gap.
    always @(posedge clk or negedge rst_n)
    begin
        axis_step_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            measured <= '0;
            elapsed_ms <= '0;
            restart <= 1'b0;
            send_wait <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                queued_outputs.push_back(pid_next_output(measured, elapsed_ms, restart));
            if (!in_valid || !in_stall)
            begin
                if (send_wait != 0)
                begin
                    in_valid <= 1'b0;
                    send_wait <= send_wait - 1;
                end
                else if (steps_to_send.size() != 0)
                begin
                    nxt = steps_to_send.pop_front();
                    measured <= nxt.meas;
                    elapsed_ms <= nxt.ms;
                    restart <= nxt.clr;
                    in_valid <= 1'b1;
                    send_wait <= pick_gap(send_gaps);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor. Each accepted output beat is checked against the
    // oldest prediction; the stall line runs in random bursts.
    always @(posedge clk or negedge rst_n)
    begin
        axis_out_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (queued_outputs.size() == 0)
                begin
                    $display("%0t: output beat with nothing awaited: drive %h settled %b error %h",
                             $time, drive, settled, error_out);
                    fail_count++;
                end
                else
                begin
                    want = queued_outputs.pop_front();
                    if (drive !== want.drive)
                    begin
                        $display("%0t: drive expected %h actual %h", $time, want.drive, drive);
                        fail_count++;
                    end
                    if (settled !== want.settled)
                    begin
                        $display("%0t: settled expected %b actual %b",
                                 $time, want.settled, settled);
                        fail_count++;
                    end
                    if (error_out !== want.err)
                    begin
                        $display("%0t: error_out expected %h actual %h",
                                 $time, want.err, error_out);
                        fail_count++;
                    end
                end
            end
            if (stall_left != 0)
            begin
                out_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else
            begin
                out_stall <= 1'b0;
                stall_left <= pick_gap(sink_stalls);
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: no progress within the cycle limit", $time);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int ph;
        int n;
        int k;
        int kind;
        int burst_len;
        int r;
        longint err;
        longint base;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset configuration: zero gains, so only the error and the settle
        // flag carry information. The tolerance edge is just outside the
        // band, and ten in-band steps reach the reset settle limit.
        send_gaps = 1'b0;
        sink_stalls = 1'b1;
        push_step(32'd4588, 16'd1, 1'b0);
        push_step(-32'sd4587, 16'd0, 1'b0);
        push_step(32'd4587, 16'd65535, 1'b0);
        for (k = 0; k < 8; k++)
            push_step('0, 16'(k), 1'b0);
        push_step('0, 16'd2, 1'b1);
        wait_quiet();

        // Moderate gains and a short settle limit. The error saturates at
        // the most negative measurement, and a restart drops the settle count.
        write_reg(REG_TARGET, 32'h0005_0000);
        write_reg(REG_GAIN_P, 32'h0001_8000);
        write_reg(REG_GAIN_I, 32'h0000_0400);
        write_reg(REG_GAIN_D, 32'h0000_3333);
        write_reg(REG_TOLERANCE, 32'h0000_1000);
        write_reg(REG_SETTLE_LIMIT, 32'd2);
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        push_step(32'h8000_0000, 16'd1, 1'b0);
        push_step(32'h7FFF_FFFF, 16'd0, 1'b0);
        push_step(meas_for(64'sd4096), 16'd65535, 1'b0);
        push_step(meas_for(-64'sd4095), 16'd3, 1'b0);
        push_step(meas_for(0), 16'd1, 1'b0);
        push_step(meas_for(1), 16'd7, 1'b0);
        push_step(meas_for(0), 16'd2, 1'b1);
        wait_quiet();

        // Extreme gains and target with zero tolerance, so the drive saturates
        // and nothing counts as on target.
        write_reg(REG_TARGET, 32'h8000_0000);
        write_reg(REG_GAIN_P, 32'h8000_0000);
        write_reg(REG_GAIN_I, 32'h7FFF_FFFF);
        write_reg(REG_GAIN_D, 32'h7FFF_FFFF);
        write_reg(REG_TOLERANCE, 32'd0);
        write_reg(REG_SETTLE_LIMIT, 32'd15);
        push_step(32'h7FFF_FFFF, 16'd1, 1'b1);
        push_step(32'h8000_0000, 16'd65535, 1'b0);
        push_step('0, 16'd1, 1'b0);
        wait_quiet();

        // A settle limit of zero is always met, so every beat is settled.
        write_reg(REG_SETTLE_LIMIT, 32'd0);
        push_step(32'h0000_1234, 16'd0, 1'b0);
        push_step(32'h7FFF_FFFF, 16'd5, 1'b0);
        wait_quiet();

        // Random phases: a fresh configuration each time, then mostly runs
        // of beats whose error shrinks toward the band so the settle logic is
        // exercised, mixed with full-range noise and band-edge beats.
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            r = $urandom_range(99);
            if (r < 15)
                write_reg(REG_TARGET, $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000);
            else if (r < 45)
                write_reg(REG_TARGET, $urandom());
            else
                write_reg(REG_TARGET, meas_for(-longint'($signed(32'($urandom_range(0,
                                          32'h0100_0000))) - 32'sh0080_0000)));
            write_reg(REG_GAIN_P, rand_gain());
            write_reg(REG_GAIN_I, rand_gain());
            write_reg(REG_GAIN_D, rand_gain());
            r = $urandom_range(99);
            if (r < 10)
                write_reg(REG_TOLERANCE, 32'd0);
            else if (r < 15)
                write_reg(REG_TOLERANCE, 32'h7FFF_FFFF);
            else if (r < 25)
                write_reg(REG_TOLERANCE, $urandom());
            else
                write_reg(REG_TOLERANCE, $urandom_range(1, 32'h0002_0000));
            r = $urandom_range(99);
            if (r < 10)
                write_reg(REG_SETTLE_LIMIT, 32'd0);
            else if (r < 20)
                write_reg(REG_SETTLE_LIMIT, 32'd15);
            else
                write_reg(REG_SETTLE_LIMIT, $urandom_range(1, 6));

            // One phase in four runs with no idling on either side.
            r = $urandom_range(3);
            send_gaps = (r != 0);
            sink_stalls = (r != 0) && (r != 1);
            if (r == 1)
                send_gaps = 1'b1;

            base = (tol_reg > 31'd16) ? longint'(tol_reg) : 64'sd4096;
            n = 0;
            while (n < BEATS_PER_PHASE)
            begin
                kind = $urandom_range(99);
                if (kind < 70)
                begin
                    burst_len = $urandom_range(3, 18);
                    err = longint'($urandom_range(0, 64)) * base;
                    if ($urandom_range(1))
                        err = -err;
                    for (k = 0; k < burst_len; k++)
                    begin
                        push_step(meas_for(err), pick_ms(),
                                  (k == 0) ? ($urandom_range(9) < 3) : ($urandom_range(99) < 3));
                        err = err * longint'($urandom_range(0, 3)) / 4
                              + longint'($urandom_range(0, 8)) - 4;
                    end
                    n += burst_len;
                end
                else if (kind < 88)
                begin
                    push_step($urandom(), pick_ms(), $urandom_range(99) < 10);
                    n++;
                end
                else
                begin
                    case ($urandom_range(4))
                        0: err = longint'(tol_reg);
                        1: err = -longint'(tol_reg);
                        2: err = longint'(tol_reg) - 1;
                        3: err = 1 - longint'(tol_reg);
                        default: err = 0;
                    endcase
                    push_step(meas_for(err), pick_ms(), 1'b0);
                    n++;
                end
            end
            wait_quiet();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
src/pidsc_pkg.sv
src/pid_axis_with_settle_count_core.sv
src/pidsc_checker.sv
tb/pid_axis_with_settle_count_core_tb.sv
